>>> hdl/aqwc_pkg.sv
// Shared types and constants for the air quality window classifier.
// Holds the configuration layout, sample record, verdict codes and sequencer states.
// No dependencies.
package aqwc_pkg;

    // Default window depth in samples.
    localparam int AQWC_WINDOW = 30;

    // Saturation value of the alarm and good run counters.
    localparam logic [2:0] RUN_MAX = 3'd7;

    // Configuration reset values.
    localparam logic [15:0] CFG_RST_WARMUP_MS  = 16'd10000;
    localparam logic [15:0] CFG_RST_VOC_DROP   = 16'd500;
    localparam logic [13:0] CFG_RST_HUM_LIMIT  = 14'd7500;
    localparam logic [14:0] CFG_RST_TEMP_RISE  = 15'd200;
    localparam logic [15:0] CFG_RST_BASE_BAND  = 16'd200;
    localparam logic [2:0]  CFG_RST_CONFIRM    = 3'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WARMUP_MS = 3'd0,
        CFG_VOC_DROP  = 3'd1,
        CFG_HUM_LIMIT = 3'd2,
        CFG_TEMP_RISE = 3'd3,
        CFG_BASE_BAND = 3'd4,
        CFG_CONFIRM   = 3'd5
    } t_cfg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0] warmup_ms;
        logic [15:0] voc_drop_limit;
        logic [13:0] humidity_limit;
        logic [14:0] temp_rise_limit;
        logic [15:0] baseline_band;
        logic [2:0]  confirm_runs;
    } t_cfg;

    // One sensor sample as stored in the window memory.
    typedef struct packed {
        logic        [15:0] voc;
        logic        [13:0] hum;
        logic signed [14:0] temp;
    } t_sample;

    // Reported verdict codes.
    typedef enum logic [1:0] {
        VERDICT_WARM = 2'd0,
        VERDICT_POOR = 2'd1,
        VERDICT_GOOD = 2'd2
    } t_verdict;

    // Channel currently handed to the shared divider.
    typedef enum logic [1:0] {
        CH_VOC  = 2'd0,
        CH_HUM  = 2'd1,
        CH_TEMP = 2'd2
    } t_chan;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_UPD    = 3'd1,
        S_DSTART = 3'd2,
        S_DWAIT  = 3'd3,
        S_EVAL   = 3'd4,
        S_OUT    = 3'd5
    } t_state;

endpackage

>>> hdl/aqwc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Divides an unsigned dividend by a small unsigned nonzero divisor.
// Depends on nothing outside this file.
module aqwc_div #(
    parameter int DW = 21,
    parameter int CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] r_dq;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dvs;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_dq[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= NW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DW-2:0], ge};
            r_rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

>>> hdl/aqwc_ring.sv
// Sample window memory with write pointer, fill count and running channel sums.
// Uses t_sample from aqwc_pkg.
// The oldest entry is read in the cycle before its overwrite so the sums stay exact.
module aqwc_ring
    import aqwc_pkg::*;
#(
    parameter int WINDOW = AQWC_WINDOW,
    parameter int CW     = $clog2(WINDOW + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic                     i_wr_en,
    input  t_sample                  i_wr_data,
    output logic [CW-1:0]            o_fill,
    output logic [16+CW-1:0]         o_vsum,
    output logic [14+CW-1:0]         o_hsum,
    output logic signed [15+CW-1:0]  o_tsum
);

    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int VSW = 16 + CW;
    localparam int HSW = 14 + CW;
    localparam int TSW = 15 + CW;

    t_sample                r_mem [WINDOW];
    t_sample                r_old;
    logic [AW-1:0]          r_wp;
    logic [CW-1:0]          r_fill;
    logic [VSW-1:0]         r_vsum;
    logic [HSW-1:0]         r_hsum;
    logic signed [TSW-1:0]  r_tsum;

    logic                   full;
    t_sample                sub;
    logic [VSW-1:0]         n_vsum;
    logic [HSW-1:0]         n_hsum;
    logic signed [TSW-1:0]  n_tsum;
    logic [AW-1:0]          n_wp;

    // Window memory: read the entry about to be replaced, then overwrite it.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_old <= r_mem[r_wp];
        end
    end

    // Add the new sample; drop the replaced one only once the window is full.
    always_comb begin
        full   = (r_fill == CW'(WINDOW));
        sub    = full ? r_old : '0;
        n_vsum = r_vsum + {{CW{1'b0}}, i_wr_data.voc} - {{CW{1'b0}}, sub.voc};
        n_hsum = r_hsum + {{CW{1'b0}}, i_wr_data.hum} - {{CW{1'b0}}, sub.hum};
        n_tsum = r_tsum + {{CW{i_wr_data.temp[14]}}, i_wr_data.temp}
                        - {{CW{sub.temp[14]}}, sub.temp};
        n_wp   = (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
    end

    // Pointer, fill count and sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_vsum <= '0;
            r_hsum <= '0;
            r_tsum <= '0;
        end else if (i_wr_en) begin
            r_wp   <= n_wp;
            r_vsum <= n_vsum;
            r_hsum <= n_hsum;
            r_tsum <= n_tsum;
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_fill = r_fill;
    assign o_vsum = r_vsum;
    assign o_hsum = r_hsum;
    assign o_tsum = r_tsum;

endmodule

>>> hdl/aqwc_judge.sv
// Alarm decision, run counters, verdict and baseline tracking.
// Uses t_cfg, t_verdict and RUN_MAX from aqwc_pkg.
// State advances once per classified transaction on i_eval.
module aqwc_judge
    import aqwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_eval,
    input  t_cfg               i_cfg,
    input  logic [15:0]        i_vavg,
    input  logic [13:0]        i_havg,
    input  logic signed [14:0] i_tavg,
    output t_verdict           o_verdict,
    output logic               o_alarm
);

    logic               r_base_valid;
    logic [15:0]        r_base_voc;
    logic signed [14:0] r_base_temp;
    logic [2:0]         r_alarm_run;
    logic [2:0]         r_good_run;
    logic               r_last_good;
    logic               r_alarm;

    logic [15:0]        bv;
    logic signed [14:0] bt;
    logic signed [16:0] rise;
    logic               alarm;
    logic [2:0]         n_alarm_run;
    logic [2:0]         n_good_run;
    logic               n_last_good;
    logic               track_voc;
    logic [18:0]        voc_mix;
    logic signed [18:0] bt_ext;
    logic signed [18:0] temp_mix;
    logic signed [18:0] temp_adj;
    logic [15:0]        n_base_voc;
    logic signed [14:0] n_base_temp;

    // Alarm tests against the baselines, which the first classified sample sets.
    always_comb begin
        bv    = r_base_valid ? r_base_voc  : i_vavg;
        bt    = r_base_valid ? r_base_temp : i_tavg;
        rise  = {{2{i_tavg[14]}}, i_tavg} - {{2{bt[14]}}, bt};
        alarm = (({1'b0, i_vavg} + {1'b0, i_cfg.voc_drop_limit}) < {1'b0, bv})
             || (i_havg > i_cfg.humidity_limit)
             || (rise > $signed({2'b00, i_cfg.temp_rise_limit}));
    end

    // Saturating run counters and the held verdict.
    always_comb begin
        n_last_good = r_last_good;
        if (alarm) begin
            n_alarm_run = (r_alarm_run == RUN_MAX) ? RUN_MAX : r_alarm_run + 1'b1;
            n_good_run  = '0;
            if (n_alarm_run >= i_cfg.confirm_runs) begin
                n_last_good = 1'b0;
            end
        end else begin
            n_good_run  = (r_good_run == RUN_MAX) ? RUN_MAX : r_good_run + 1'b1;
            n_alarm_run = '0;
            if (n_good_run >= i_cfg.confirm_runs) begin
                n_last_good = 1'b1;
            end
        end
    end

    // Baselines move one eighth toward the averages on samples without an alarm; the VOC
    // baseline only while its average is below baseline plus band. The temperature division truncates toward zero.
    always_comb begin
        track_voc   = ({1'b0, i_vavg} < ({1'b0, bv} + {1'b0, i_cfg.baseline_band}));
        voc_mix     = ({3'b000, bv} << 3) - {3'b000, bv} + {3'b000, i_vavg};
        bt_ext      = {{4{bt[14]}}, bt};
        temp_mix    = (bt_ext <<< 3) - bt_ext + {{4{i_tavg[14]}}, i_tavg};
        temp_adj    = temp_mix[18] ? temp_mix + 19'sd7 : temp_mix;
        n_base_voc  = bv;
        n_base_temp = bt;
        if (!alarm) begin
            if (track_voc) begin
                n_base_voc = voc_mix[18:3];
            end
            n_base_temp = temp_adj[17:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_valid <= 1'b0;
            r_base_voc   <= '0;
            r_base_temp  <= '0;
            r_alarm_run  <= '0;
            r_good_run   <= '0;
            r_last_good  <= 1'b0;
            r_alarm      <= 1'b0;
        end else if (i_eval) begin
            r_base_valid <= 1'b1;
            r_base_voc   <= n_base_voc;
            r_base_temp  <= n_base_temp;
            r_alarm_run  <= n_alarm_run;
            r_good_run   <= n_good_run;
            r_last_good  <= n_last_good;
            r_alarm      <= alarm;
        end
    end

    assign o_verdict = r_last_good ? VERDICT_GOOD : VERDICT_POOR;
    assign o_alarm   = r_alarm;

endmodule

>>> hdl/air_quality_window_classifier.sv
// Top level of the air quality window classifier.
// Instantiates aqwc_ring, aqwc_div and aqwc_judge; types come from aqwc_pkg.
// Holds the configuration registers, the sequencer and the result register.
//
// Usage:
// - Input channel: i_in_valid with o_in_stall carries one sensor sample per
//   transaction. Output channel: o_out_valid with i_out_stall carries one
//   result per sample, in order.
// - The block works on one sample at a time and stalls its input until the
//   result has been placed in the output register.
// - A sample still inside the warm-up time goes from the window update straight
//   to the output register. A classified sample also passes through a divider
//   start and wait per channel, as the shared divider produces the three channel
//   averages one after another at one quotient bit per cycle, then evaluation.
//   A new sample is taken the cycle after the result loads.
// - Window sums are kept running, so no pass over the window entries is needed.
// - When the receiver stalls, the result waits in the output register; the
//   next sample may be accepted and worked on, and its result waits until the
//   register frees.
// - Reset empties the window, clears the start time, baselines and run
//   counters, and restores the configuration defaults. Configuration writes
//   take effect at once and are meant for idle periods.
module air_quality_window_classifier
    import aqwc_pkg::*;
#(
    parameter int WINDOW = AQWC_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_voc_sample,
    input  logic signed [14:0] i_temperature,
    input  logic [13:0]        i_humidity,
    input  logic [31:0]        i_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_verdict,
    output logic               o_alarm_now,
    output logic [15:0]        o_voc_average,
    output logic [13:0]        o_humidity_average,
    output logic signed [14:0] o_temperature_average
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int DW = 16 + CW;

    t_cfg                  r_cfg;
    t_state                r_state;
    t_state                n_state;
    t_chan                 r_chan;
    t_sample               r_sample;
    logic                  r_started;
    logic [31:0]           r_start_time;
    logic                  r_warm;
    logic [15:0]           r_vavg;
    logic [13:0]           r_havg;
    logic signed [14:0]    r_tavg;
    logic                  r_out_valid;
    t_verdict              r_verdict;
    logic                  r_alarm;
    logic [15:0]           r_voc_out;
    logic [13:0]           r_hum_out;
    logic signed [14:0]    r_temp_out;

    logic                  accept;
    logic                  ring_wr;
    logic                  div_start;
    logic                  judge_eval;
    logic                  out_load;
    logic [31:0]           elapsed;
    logic [CW-1:0]         fill;
    logic [DW-1:0]         vsum;
    logic [14+CW-1:0]      hsum;
    logic signed [15+CW-1:0] tsum;
    logic [DW-1:0]         tsum_ext;
    logic [DW-1:0]         tmag;
    logic [DW-1:0]         dividend;
    logic                  div_busy;
    logic                  div_done;
    logic [DW-1:0]         quot;
    logic [14:0]           tquot;
    t_verdict              judge_verdict;
    logic                  judge_alarm;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_ms       <= CFG_RST_WARMUP_MS;
            r_cfg.voc_drop_limit  <= CFG_RST_VOC_DROP;
            r_cfg.humidity_limit  <= CFG_RST_HUM_LIMIT;
            r_cfg.temp_rise_limit <= CFG_RST_TEMP_RISE;
            r_cfg.baseline_band   <= CFG_RST_BASE_BAND;
            r_cfg.confirm_runs    <= CFG_RST_CONFIRM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WARMUP_MS: r_cfg.warmup_ms       <= i_cfg_data;
                CFG_VOC_DROP:  r_cfg.voc_drop_limit  <= i_cfg_data;
                CFG_HUM_LIMIT: r_cfg.humidity_limit  <= i_cfg_data[13:0];
                CFG_TEMP_RISE: r_cfg.temp_rise_limit <= i_cfg_data[14:0];
                CFG_BASE_BAND: r_cfg.baseline_band   <= i_cfg_data;
                CFG_CONFIRM:   r_cfg.confirm_runs    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UPD;
            S_UPD:    n_state = r_warm ? S_OUT : S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) begin
                    n_state = (r_chan == CH_TEMP) ? S_EVAL : S_DSTART;
                end
            end
            S_EVAL:   n_state = S_OUT;
            S_OUT:    if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        accept     = (r_state == S_IDLE) && i_in_valid;
        ring_wr    = (r_state == S_UPD);
        div_start  = (r_state == S_DSTART);
        judge_eval = (r_state == S_EVAL);
        out_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Time since the first sample, which wraps with the timestamp.
    assign elapsed = i_time_ms - (r_started ? r_start_time : i_time_ms);

    // Start time capture and the warm-up decision for the accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_start_time <= '0;
            r_warm       <= 1'b0;
        end else if (accept) begin
            r_warm <= (elapsed < {16'd0, r_cfg.warmup_ms});
            if (!r_started) begin
                r_started    <= 1'b1;
                r_start_time <= i_time_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample.voc  <= i_voc_sample;
            r_sample.hum  <= i_humidity;
            r_sample.temp <= i_temperature;
        end
    end

    aqwc_ring #(
        .WINDOW (WINDOW),
        .CW     (CW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (ring_wr),
        .i_wr_data (r_sample),
        .o_fill    (fill),
        .o_vsum    (vsum),
        .o_hsum    (hsum),
        .o_tsum    (tsum)
    );

    // Divider operand: the temperature sum is divided as a magnitude.
    always_comb begin
        tsum_ext = {tsum[15+CW-1], tsum};
        tmag     = tsum[15+CW-1] ? (~tsum_ext + 1'b1) : tsum_ext;
        case (r_chan)
            CH_VOC:  dividend = vsum;
            CH_HUM:  dividend = {2'b00, hsum};
            CH_TEMP: dividend = tmag;
            default: dividend = vsum;
        endcase
    end

    aqwc_div #(
        .DW (DW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (fill),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Quotient capture; the temperature sign goes back on after division.
    assign tquot = quot[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= CH_VOC;
        end else if (ring_wr) begin
            r_chan <= CH_VOC;
        end else if ((r_state == S_DWAIT) && div_done) begin
            case (r_chan)
                CH_VOC:  r_chan <= CH_HUM;
                CH_HUM:  r_chan <= CH_TEMP;
                default: r_chan <= CH_VOC;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DWAIT) && div_done) begin
            case (r_chan)
                CH_VOC:  r_vavg <= quot[15:0];
                CH_HUM:  r_havg <= quot[13:0];
                CH_TEMP: r_tavg <= tsum[15+CW-1] ? -$signed(tquot) : $signed(tquot);
                default: ;
            endcase
        end
    end

    aqwc_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_eval    (judge_eval),
        .i_cfg     (r_cfg),
        .i_vavg    (r_vavg),
        .i_havg    (r_havg),
        .i_tavg    (r_tavg),
        .o_verdict (judge_verdict),
        .o_alarm   (judge_alarm)
    );

    // Result register: a warming-up transaction reports zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_warm) begin
                r_verdict  <= VERDICT_WARM;
                r_alarm    <= 1'b0;
                r_voc_out  <= '0;
                r_hum_out  <= '0;
                r_temp_out <= '0;
            end else begin
                r_verdict  <= judge_verdict;
                r_alarm    <= judge_alarm;
                r_voc_out  <= r_vavg;
                r_hum_out  <= r_havg;
                r_temp_out <= r_tavg;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_verdict             = r_verdict;
    assign o_alarm_now           = r_alarm;
    assign o_voc_average         = r_voc_out;
    assign o_humidity_average    = r_hum_out;
    assign o_temperature_average = r_temp_out;

    // A warming-up result carries no alarm and zero averages.
    a_warm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict == VERDICT_WARM)) |->
        (!r_alarm && (r_voc_out == '0) && (r_hum_out == '0) && (r_temp_out == '0)))
        else $error("warming-up result carries nonzero fields");

    // An accepted transaction always goes on to update the window.
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD))
        else $error("accepted transaction did not reach the window update");

    // The divider is never restarted while it is still working.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Classification only runs with at least one sample in the window.
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (fill != '0))
        else $error("division started with an empty window");

endmodule
